// ===== rtl/core/ils_pkg.sv =====
package ils_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int KIND_W = 3;
  localparam int ST_W   = 2;

  // request codes
  localparam logic [KIND_W-1:0] REQ_GET    = 3'd0;
  localparam logic [KIND_W-1:0] REQ_HEAD   = 3'd1;
  localparam logic [KIND_W-1:0] REQ_TAIL   = 3'd2;
  localparam logic [KIND_W-1:0] REQ_INDEX  = 3'd3;
  localparam logic [KIND_W-1:0] REQ_DELETE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    RV_ZERO = 2'd0,
    RV_NEG  = 2'd1,
    RV_MEM  = 2'd2
  } rv_sel_t;

  typedef enum logic {
    WR_MEM = 1'b0,
    WR_VAL = 1'b1
  } wr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic            val_load;
    logic            rd_en;
    logic            wr_en;
    wr_sel_t         wr_sel;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            out_load;
    rv_sel_t         rv_sel;
    logic [ST_W-1:0] status;
  } ils_cmd_t;

endpackage

// ===== rtl/core/ils_if.sv =====
interface ils_in_if
  import ils_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       req_type;
  logic signed [POS_W-1:0] position;
  logic signed [VAL_W-1:0] new_value;

  modport source (output valid, output req_type, output position, output new_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input new_value,
                  output ready);
endinterface

interface ils_out_if
  import ils_pkg::*;
#(
  parameter int LEN_W = $clog2(CAPACITY_DEF + 1)
) ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [LEN_W-1:0]        list_length;

  modport source (output valid, output read_value, output status, output list_length,
                  input ready);
  modport sink   (input valid, input read_value, input status, input list_length,
                  output ready);
endinterface

// ===== rtl/core/ils_datapath.sv =====
module ils_datapath
  import ils_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ils_cmd_t                cmd,
  input  logic [ADDR_W-1:0]       rd_addr,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic signed [VAL_W-1:0] new_value,
  output logic [LEN_W-1:0]        count,
  output logic signed [VAL_W-1:0] read_value,
  output logic [ST_W-1:0]         status,
  output logic [LEN_W-1:0]        list_length
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;
  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rv;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] read_value_r;
  logic [ST_W-1:0]  status_r;
  logic [LEN_W-1:0] length_r;

  assign wdata = (cmd.wr_sel == WR_VAL) ? value_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_load) begin
      value_r <= new_value;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + LEN_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    case (cmd.rv_sel)
      RV_MEM:  rv = rdata_r;
      RV_NEG:  rv = '1;
      default: rv = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value_r <= rv;
      status_r     <= cmd.status;
      length_r     <= count_r;
    end
  end

  assign count       = count_r;
  assign read_value  = read_value_r;
  assign status      = status_r;
  assign list_length = length_r;

endmodule

// ===== rtl/core/ils_ctrl.sv =====
module ils_ctrl
  import ils_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KIND_W-1:0]       in_req_type,
  input  logic signed [POS_W-1:0] in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  logic [LEN_W-1:0]        count,
  output ils_cmd_t                cmd,
  output logic [ADDR_W-1:0]       rd_addr,
  output logic [ADDR_W-1:0]       wr_addr
);

  // compare width: holds any count and any position + 1
  localparam int CW = ((LEN_W > POS_W - 1) ? LEN_W : POS_W - 1) + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_WRVAL  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ADDR_W-1:0]   p_r, p_nxt;        // insert target, or last read of a delete
  logic [ADDR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0]   last_r, last_nxt;
  logic                pend_r, pend_nxt;
  logic [ST_W-1:0]     st_r, st_nxt;
  rv_sel_t             rv_sel_r, rv_sel_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CW-1:0] pos_ext, cnt_ext, tgt_ext;
  logic          pos_neg, is_del, full;

  assign pos_neg = pos_r[POS_W-1];
  assign pos_ext = CW'(pos_r[POS_W-2:0]);
  assign cnt_ext = CW'(count);
  assign is_del  = (kind_r == REQ_DELETE);
  assign full    = (cnt_ext == CW'(CAPACITY));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    case (kind_r)
      REQ_HEAD: tgt_ext = '0;
      REQ_TAIL: tgt_ext = cnt_ext;
      default:  tgt_ext = pos_ext;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    p_nxt         = p_r;
    rd_ptr_nxt    = rd_ptr_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    st_nxt        = st_r;
    rv_sel_nxt    = rv_sel_r;
    out_valid_nxt = out_valid_r;

    cmd          = '0;
    cmd.wr_sel   = WR_MEM;
    cmd.rv_sel   = rv_sel_r;
    cmd.status   = st_r;
    rd_addr      = rd_ptr_r;
    wr_addr      = is_del ? last_r - ADDR_W'(1) : last_r + ADDR_W'(1);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_req_type;
          pos_nxt      = in_position;
          cmd.val_load = 1'b1;
          state_nxt    = S_DECODE;
        end
      end

      S_DECODE: begin
        st_nxt     = ST_DONE;
        rv_sel_nxt = RV_ZERO;
        pend_nxt   = 1'b0;
        state_nxt  = S_FIN;
        case (kind_r)
          REQ_GET: begin
            if (pos_neg || pos_ext >= cnt_ext) begin
              st_nxt     = ST_RANGE;
              rv_sel_nxt = RV_NEG;
            end else begin
              cmd.rd_en  = 1'b1;
              rd_addr    = ADDR_W'(pos_ext);
              rv_sel_nxt = RV_MEM;
            end
          end
          REQ_HEAD, REQ_TAIL, REQ_INDEX: begin
            if (kind_r == REQ_INDEX && (pos_neg || pos_ext > cnt_ext)) begin
              st_nxt = ST_RANGE;
            end else if (full) begin
              st_nxt = ST_FULL;
            end else begin
              p_nxt = ADDR_W'(tgt_ext);
              if (cnt_ext > tgt_ext) begin
                rd_ptr_nxt = ADDR_W'(cnt_ext - CW'(1));
                state_nxt  = S_SHIFT;
              end else begin
                state_nxt = S_WRVAL;
              end
            end
          end
          REQ_DELETE: begin
            if (pos_neg || pos_ext >= cnt_ext) begin
              st_nxt = ST_RANGE;
            end else if (pos_ext + CW'(1) < cnt_ext) begin
              rd_ptr_nxt = ADDR_W'(pos_ext + CW'(1));
              p_nxt      = ADDR_W'(cnt_ext - CW'(1));
              state_nxt  = S_SHIFT;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // one read and, once a read is pending, one write per cycle
      S_SHIFT: begin
        cmd.rd_en  = 1'b1;
        cmd.wr_en  = pend_r;
        pend_nxt   = 1'b1;
        last_nxt   = rd_ptr_r;
        rd_ptr_nxt = is_del ? rd_ptr_r + ADDR_W'(1) : rd_ptr_r - ADDR_W'(1);
        if (rd_ptr_r == p_r) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        cmd.wr_en = 1'b1;
        if (is_del) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_WRVAL;
        end
      end

      S_WRVAL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_VAL;
        wr_addr     = p_r;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    p_r      <= p_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    last_r   <= last_nxt;
    pend_r   <= pend_nxt;
    st_r     <= st_nxt;
    rv_sel_r <= rv_sel_nxt;
  end

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// Ordered list of signed 32-bit values, CAPACITY entries deep, with a length.
// in_ch carries one request per transfer: req_type (get, add at head, add at
// tail, add at index, delete), position and new_value. out_ch returns one
// result per request: read_value, status and the list length after it.
// One request is in work at a time; in_ch is ready only while the block idles.
// Every request passes a decode step and ends in a finish step that loads the
// output register. An insert first moves the entries at and behind its slot
// up, then writes the new value; a delete moves the entries behind its slot
// down. Entries move one per cycle, through the one read port and the one
// write port of the value memory.
// The result sits in an output register; if out_ch stalls, the block holds
// it, still takes and works one more request, and then waits with that
// second result until the output register frees.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; memory contents are not cleared and need no clearing pass.
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic     clk,
  input  logic     rst_n,
  ils_in_if.sink   in_ch,
  ils_out_if.source out_ch
);

  localparam int ADDR_W = $clog2(CAPACITY);

  ils_cmd_t          cmd;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  count;

  ils_ctrl #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .LEN_W    (LEN_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_position (in_ch.position),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .count       (count),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  ils_datapath #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .LEN_W    (LEN_W)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .new_value   (in_ch.new_value),
    .count       (count),
    .read_value  (out_ch.read_value),
    .status      (out_ch.status),
    .list_length (out_ch.list_length)
  );

endmodule

// ===== sim/tb_indexed_list_store.sv =====
module tb_indexed_list_store
  import ils_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP            = CAPACITY_DEF;
  localparam int LEN_W          = $clog2(CAP + 1);
  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 230;
  localparam int NUM_PHASES     = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 40;

  // traffic mix of a random phase
  typedef enum int {
    MIX_FILL     = 70,
    MIX_BALANCED = 32,
    MIX_DRAIN    = 12
  } mix_t;

  typedef struct {
    logic signed [VAL_W-1:0] rd;
    logic [ST_W-1:0]         st;
    logic [LEN_W-1:0]        len;
  } list_result_t;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;
    bit                      typed;
    logic signed [VAL_W-1:0] rd;
    logic [ST_W-1:0]         st;
    int                      len;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ils_in_if                     in_ch ();
  ils_out_if #(.LEN_W(LEN_W))   out_ch ();

  indexed_list_store #(.CAPACITY(CAP), .LEN_W(LEN_W)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // shadow copy of the list and the results it still owes
  logic signed [VAL_W-1:0] shadow_list[$];
  list_result_t            pending_results[$];

  int errors;
  int n_results;
  int n_get, n_insert, n_delete, n_unknown, n_range, n_full, peak_len;
  int gap_pct;
  int stall_pct;
  logic holding;
  event hold_go;
  int stall_cycles;

  plan_row_t plan [0:22];

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // applies one request to the shadow list and returns what the block must answer
  task automatic apply_request(input logic [KIND_W-1:0] kind,
                               input logic signed [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val,
                               output list_result_t res);
    int p;
    int n;
    p      = pos;
    n      = shadow_list.size();
    res.rd = '0;
    res.st = ST_DONE;
    case (kind)
      REQ_GET: begin
        n_get++;
        if (p < 0 || p >= n) begin
          res.rd = -32'sd1;
          res.st = ST_RANGE;
        end else begin
          res.rd = shadow_list[p];
        end
      end
      REQ_HEAD, REQ_TAIL, REQ_INDEX: begin
        n_insert++;
        if (kind == REQ_HEAD) p = 0;
        if (kind == REQ_TAIL) p = n;
        if (p < 0 || p > n) res.st = ST_RANGE;
        else if (n >= CAP) res.st = ST_FULL;
        else shadow_list.insert(p, val);
      end
      REQ_DELETE: begin
        n_delete++;
        if (p < 0 || p >= n) res.st = ST_RANGE;
        else shadow_list.delete(p);
      end
      default: n_unknown++;
    endcase
    if (res.st == ST_RANGE) n_range++;
    if (res.st == ST_FULL) n_full++;
    if (shadow_list.size() > peak_len) peak_len = shadow_list.size();
    res.len = LEN_W'(shadow_list.size());
  endtask

  // offers one request, waits for its transfer and records the expected result
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val,
                              input bit typed,
                              input list_result_t typed_res);
    list_result_t res;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.position  <= pos;
    in_ch.new_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(kind, pos, val, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  function automatic logic signed [POS_W-1:0] pick_pos(input int n, input bit inclusive);
    int hi;
    hi = inclusive ? n : n - 1;
    if (hi < 0 || $urandom_range(99) < 12) return POS_W'($urandom_range(255, 0));
    return POS_W'($urandom_range(hi, 0));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3, 0))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    out_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    @(hold_go);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_value !== want.rd)
          report_mismatch($sformatf("read_value %0d, expected %0d",
                                    out_ch.read_value, want.rd));
        if (out_ch.status !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.st));
        if (out_ch.list_length !== want.len)
          report_mismatch($sformatf("list_length %0d, expected %0d",
                                    out_ch.list_length, want.len));
      end
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
    $display("tb_indexed_list_store: FAIL");
    $finish;
  end

  initial begin
    list_result_t typed_res;
    mix_t mix [NUM_PHASES];
    logic [KIND_W-1:0] kind;
    logic signed [POS_W-1:0] pos;
    int r;
    int n;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_GET;
    in_ch.position  = '0;
    in_ch.new_value = '0;
    out_ch.ready    = 1'b0;
    holding         = 1'b0;
    errors          = 0;
    n_results       = 0;
    n_get           = 0;
    n_insert        = 0;
    n_delete        = 0;
    n_unknown       = 0;
    n_range         = 0;
    n_full          = 0;
    peak_len        = 0;
    gap_pct         = 0;
    stall_pct       = 0;

    // directed requests, starting from an empty list
    plan = '{
      '{REQ_GET,    8'sd0,   32'sd0,           1'b1, -32'sd1,          ST_RANGE, 0},
      '{REQ_DELETE, 8'sd0,   32'sd0,           1'b1, 32'sd0,           ST_RANGE, 0},
      '{REQ_INDEX,  8'sd1,   32'sd5,           1'b1, 32'sd0,           ST_RANGE, 0},
      '{REQ_INDEX,  8'sd0,   32'sh7FFF_FFFF,   1'b1, 32'sd0,           ST_DONE,  1},
      '{REQ_HEAD,   8'sd0,   32'sh8000_0000,   1'b1, 32'sd0,           ST_DONE,  2},
      '{REQ_TAIL,   8'sd0,   -32'sd1,          1'b1, 32'sd0,           ST_DONE,  3},
      '{REQ_GET,    8'sd0,   32'sd0,           1'b1, 32'sh8000_0000,   ST_DONE,  3},
      '{REQ_GET,    8'sd2,   32'sd0,           1'b1, -32'sd1,          ST_DONE,  3},
      '{REQ_GET,    8'sd3,   32'sd0,           1'b1, -32'sd1,          ST_RANGE, 3},
      '{REQ_GET,    8'sh80,  32'sd0,           1'b1, -32'sd1,          ST_RANGE, 3},
      '{REQ_GET,    8'sd127, 32'sd0,           1'b1, -32'sd1,          ST_RANGE, 3},
      '{REQ_INDEX,  8'sd1,   32'sd0,           1'b0, 32'sd0,           ST_DONE,  0},
      '{REQ_INDEX,  8'sd4,   32'sh5A5A_5A5A,   1'b0, 32'sd0,           ST_DONE,  0},
      '{REQ_INDEX,  8'shFF,  32'sd9,           1'b1, 32'sd0,           ST_RANGE, 5},
      '{REQ_DELETE, 8'sd5,   32'sd0,           1'b1, 32'sd0,           ST_RANGE, 5},
      '{REQ_DELETE, 8'sh80,  32'sd0,           1'b1, 32'sd0,           ST_RANGE, 5},
      '{3'd5,       8'sd0,   32'sd0,           1'b1, 32'sd0,           ST_DONE,  5},
      '{3'd6,       8'sd127, -32'sd1,          1'b1, 32'sd0,           ST_DONE,  5},
      '{3'd7,       8'shFF,  32'sh7FFF_FFFF,   1'b1, 32'sd0,           ST_DONE,  5},
      '{REQ_DELETE, 8'sd0,   32'sd0,           1'b0, 32'sd0,           ST_DONE,  0},
      '{REQ_DELETE, 8'sd3,   32'sd0,           1'b0, 32'sd0,           ST_DONE,  0},
      '{REQ_GET,    8'sd1,   32'sd0,           1'b0, 32'sd0,           ST_DONE,  0},
      '{REQ_DELETE, 8'sd1,   32'sd0,           1'b0, 32'sd0,           ST_DONE,  0}
    };
    mix = '{MIX_FILL, MIX_BALANCED, MIX_FILL, MIX_DRAIN,
            MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_BALANCED};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      typed_res.rd  = plan[i].rd;
      typed_res.st  = plan[i].st;
      typed_res.len = LEN_W'(plan[i].len);
      send_request(plan[i].kind, plan[i].pos, plan[i].val, plan[i].typed, typed_res);
    end

    // random phases; idle pattern cycles through none, sender, receiver, both
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_pct   = (ph % 4 == 1) ? 79 : (ph % 4 == 3) ? 9 : 0;
      stall_pct <= (ph % 4 == 2) ? 79 : (ph % 4 == 3) ? 9 : 0;
      if (ph == 2) -> hold_go;
      repeat (PHASE_ITEMS) begin
        n = shadow_list.size();
        r = $urandom_range(99);
        if (r < 4) begin
          kind = KIND_W'($urandom_range(7, 5));
          pos  = POS_W'($urandom_range(255, 0));
        end else if (r < 4 + int'(mix[ph])) begin
          case ($urandom_range(2, 0))
            0: kind = REQ_HEAD;
            1: kind = REQ_TAIL;
            default: kind = REQ_INDEX;
          endcase
          pos = (kind == REQ_INDEX) ? pick_pos(n, 1'b1) : POS_W'($urandom_range(255, 0));
        end else begin
          kind = r[0] ? REQ_DELETE : REQ_GET;
          pos  = pick_pos(n, 1'b0);
        end
        send_request(kind, pos, pick_value(), 1'b0, typed_res);
      end
      in_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("run covered %0d gets, %0d inserts, %0d deletes, %0d unknown requests; %0d results",
             n_get, n_insert, n_delete, n_unknown, n_results);
    $display("  %0d out-of-range rejects, %0d full-store rejects, peak length %0d, %0d errors",
             n_range, n_full, peak_len, errors);
    if (errors == 0) begin
      $display("tb_indexed_list_store: PASS");
    end else begin
      $display("tb_indexed_list_store: FAIL");
    end
    $finish;
  end

endmodule
